// File: rtl/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
package bba_pkg;

    localparam int EXP_W  = 5;
    localparam int WIDE_W = 17;
    localparam int STEP_W = 5;
    localparam int UOP_W  = 4;
    localparam int COND_W = 3;

    localparam logic [EXP_W-1:0] TAKEN = 5'h1f;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NOT_ALC = 2'd3;

    localparam logic [UOP_W-1:0] U_NONE      = 4'd0;
    localparam logic [UOP_W-1:0] U_DESC_INIT = 4'd1;
    localparam logic [UOP_W-1:0] U_READ_LEFT = 4'd2;
    localparam logic [UOP_W-1:0] U_DESC_STEP = 4'd3;
    localparam logic [UOP_W-1:0] U_MARK      = 4'd4;
    localparam logic [UOP_W-1:0] U_READ_SIB  = 4'd5;
    localparam logic [UOP_W-1:0] U_UP_WRITE  = 4'd6;
    localparam logic [UOP_W-1:0] U_LEAF_INIT = 4'd7;
    localparam logic [UOP_W-1:0] U_READ_IDX  = 4'd8;
    localparam logic [UOP_W-1:0] U_CLIMB     = 4'd9;
    localparam logic [UOP_W-1:0] U_RESTORE   = 4'd10;
    localparam logic [UOP_W-1:0] U_SET_UNITS = 4'd11;
    localparam logic [UOP_W-1:0] U_ST1       = 4'd12;
    localparam logic [UOP_W-1:0] U_ST2       = 4'd13;
    localparam logic [UOP_W-1:0] U_ST3       = 4'd14;
    localparam logic [UOP_W-1:0] U_FINISH    = 4'd15;

    localparam logic [COND_W-1:0] C_NONE       = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
    localparam logic [COND_W-1:0] C_ALLOC_FAIL = 3'd2;
    localparam logic [COND_W-1:0] C_LVL_EQ_K   = 3'd3;
    localparam logic [COND_W-1:0] C_IDX_ZERO   = 3'd4;
    localparam logic [COND_W-1:0] C_TAKEN      = 3'd5;
    localparam logic [COND_W-1:0] C_OFF_BAD    = 3'd6;
    localparam logic [COND_W-1:0] C_ROOT_FULL  = 3'd7;

    localparam logic [STEP_W-1:0] S_A0     = 5'd0;
    localparam logic [STEP_W-1:0] S_A_INIT = 5'd1;
    localparam logic [STEP_W-1:0] S_A_LOOP = 5'd2;
    localparam logic [STEP_W-1:0] S_A_STEP = 5'd3;
    localparam logic [STEP_W-1:0] S_A_MARK = 5'd4;
    localparam logic [STEP_W-1:0] S_UP     = 5'd5;
    localparam logic [STEP_W-1:0] S_UP2    = 5'd6;
    localparam logic [STEP_W-1:0] S_F0     = 5'd7;
    localparam logic [STEP_W-1:0] S_F1     = 5'd8;
    localparam logic [STEP_W-1:0] S_F2     = 5'd9;
    localparam logic [STEP_W-1:0] S_F3     = 5'd10;
    localparam logic [STEP_W-1:0] S_F4     = 5'd11;
    localparam logic [STEP_W-1:0] S_F5     = 5'd12;
    localparam logic [STEP_W-1:0] S_F6     = 5'd13;
    localparam logic [STEP_W-1:0] S_F_REST = 5'd14;
    localparam logic [STEP_W-1:0] S_Q0     = 5'd15;
    localparam logic [STEP_W-1:0] S_Q1     = 5'd16;
    localparam logic [STEP_W-1:0] S_Q2     = 5'd17;
    localparam logic [STEP_W-1:0] S_Q3     = 5'd18;
    localparam logic [STEP_W-1:0] S_Q4     = 5'd19;
    localparam logic [STEP_W-1:0] S_Q5     = 5'd20;
    localparam logic [STEP_W-1:0] S_Q_HIT  = 5'd21;
    localparam logic [STEP_W-1:0] S_ST1    = 5'd22;
    localparam logic [STEP_W-1:0] S_ST2    = 5'd23;
    localparam logic [STEP_W-1:0] S_ST3    = 5'd24;
    localparam logic [STEP_W-1:0] S_DONE   = 5'd25;

    typedef struct packed {
        logic [UOP_W-1:0]  uop;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic alloc_fail;
        logic lvl_eq_k;
        logic idx_zero;
        logic taken;
        logic off_bad;
        logic root_full;
    } flags_t;

endpackage

// File: rtl/bba_seq.sv
// Microprogram sequencer: step counter, control store and branch select.
module bba_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bba_pkg::STEP_W-1:0]    entry,
    input  bba_pkg::flags_t               flags,
    input  logic                          out_free,
    output logic                          busy,
    output bba_pkg::uword_t               uword
);

    function automatic bba_pkg::uword_t ucode(input logic [bba_pkg::STEP_W-1:0] s);
        bba_pkg::uword_t w;
        w.uop    = bba_pkg::U_NONE;
        w.cond   = bba_pkg::C_NONE;
        w.target = bba_pkg::S_DONE;
        unique case (s)
            bba_pkg::S_A0:     begin w.cond = bba_pkg::C_ALLOC_FAIL; w.target = bba_pkg::S_ST1; end
            bba_pkg::S_A_INIT: w.uop = bba_pkg::U_DESC_INIT;
            bba_pkg::S_A_LOOP:
            begin
                w.uop = bba_pkg::U_READ_LEFT; w.cond = bba_pkg::C_LVL_EQ_K;
                w.target = bba_pkg::S_A_MARK;
            end
            bba_pkg::S_A_STEP:
            begin
                w.uop = bba_pkg::U_DESC_STEP; w.cond = bba_pkg::C_ALWAYS;
                w.target = bba_pkg::S_A_LOOP;
            end
            bba_pkg::S_A_MARK:
            begin
                w.uop = bba_pkg::U_MARK; w.cond = bba_pkg::C_ALWAYS; w.target = bba_pkg::S_UP;
            end
            bba_pkg::S_UP:
            begin
                w.uop = bba_pkg::U_READ_SIB; w.cond = bba_pkg::C_IDX_ZERO;
                w.target = bba_pkg::S_DONE;
            end
            bba_pkg::S_UP2:
            begin
                w.uop = bba_pkg::U_UP_WRITE; w.cond = bba_pkg::C_ALWAYS; w.target = bba_pkg::S_UP;
            end
            bba_pkg::S_F0:     begin w.cond = bba_pkg::C_OFF_BAD; w.target = bba_pkg::S_ST2; end
            bba_pkg::S_F1:     begin w.cond = bba_pkg::C_ROOT_FULL; w.target = bba_pkg::S_ST3; end
            bba_pkg::S_F2:     w.uop = bba_pkg::U_LEAF_INIT;
            bba_pkg::S_F3:     w.uop = bba_pkg::U_READ_IDX;
            bba_pkg::S_F4:     begin w.cond = bba_pkg::C_TAKEN; w.target = bba_pkg::S_F_REST; end
            bba_pkg::S_F5:     begin w.cond = bba_pkg::C_IDX_ZERO; w.target = bba_pkg::S_ST3; end
            bba_pkg::S_F6:
            begin
                w.uop = bba_pkg::U_CLIMB; w.cond = bba_pkg::C_ALWAYS; w.target = bba_pkg::S_F3;
            end
            bba_pkg::S_F_REST:
            begin
                w.uop = bba_pkg::U_RESTORE; w.cond = bba_pkg::C_ALWAYS; w.target = bba_pkg::S_UP;
            end
            bba_pkg::S_Q0:     begin w.cond = bba_pkg::C_OFF_BAD; w.target = bba_pkg::S_ST2; end
            bba_pkg::S_Q1:     w.uop = bba_pkg::U_LEAF_INIT;
            bba_pkg::S_Q2:     w.uop = bba_pkg::U_READ_IDX;
            bba_pkg::S_Q3:     begin w.cond = bba_pkg::C_TAKEN; w.target = bba_pkg::S_Q_HIT; end
            bba_pkg::S_Q4:     begin w.cond = bba_pkg::C_IDX_ZERO; w.target = bba_pkg::S_ST3; end
            bba_pkg::S_Q5:
            begin
                w.uop = bba_pkg::U_CLIMB; w.cond = bba_pkg::C_ALWAYS; w.target = bba_pkg::S_Q2;
            end
            bba_pkg::S_Q_HIT:  begin w.uop = bba_pkg::U_SET_UNITS; w.cond = bba_pkg::C_ALWAYS; end
            bba_pkg::S_ST1:    begin w.uop = bba_pkg::U_ST1; w.cond = bba_pkg::C_ALWAYS; end
            bba_pkg::S_ST2:    begin w.uop = bba_pkg::U_ST2; w.cond = bba_pkg::C_ALWAYS; end
            bba_pkg::S_ST3:    begin w.uop = bba_pkg::U_ST3; w.cond = bba_pkg::C_ALWAYS; end
            bba_pkg::S_DONE:   w.uop = bba_pkg::U_FINISH;
            default:           w.cond = bba_pkg::C_ALWAYS;
        endcase
        return w;
    endfunction

    logic [bba_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       jump;

    always_comb
    begin
        if (busy_reg)
        begin
            uword = ucode(step_reg);
        end
        else
        begin
            uword.uop    = bba_pkg::U_NONE;
            uword.cond   = bba_pkg::C_NONE;
            uword.target = bba_pkg::S_DONE;
        end
    end

    always_comb
    begin
        unique case (uword.cond)
            bba_pkg::C_NONE:       jump = 1'b0;
            bba_pkg::C_ALWAYS:     jump = 1'b1;
            bba_pkg::C_ALLOC_FAIL: jump = flags.alloc_fail;
            bba_pkg::C_LVL_EQ_K:   jump = flags.lvl_eq_k;
            bba_pkg::C_IDX_ZERO:   jump = flags.idx_zero;
            bba_pkg::C_TAKEN:      jump = flags.taken;
            bba_pkg::C_OFF_BAD:    jump = flags.off_bad;
            bba_pkg::C_ROOT_FULL:  jump = flags.root_full;
            default:               jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = entry;
        end
        else if (busy_reg)
        begin
            if (uword.uop == bba_pkg::U_FINISH)
            begin
                if (out_free)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (jump)
            begin
                step_next = uword.target;
            end
            else
            begin
                step_next = step_reg + bba_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bba_pkg::S_DONE;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: tree memory, datapath and stream ports.
//
// Buddy allocator over POOL_UNITS units (a power of two). The free-exponent
// tree lives in a single memory with a registered read, so every tree level
// visited is read first and used afterwards, on the way down or up. Allocate
// walks down and back up, free and query climb from the leaf. Mode 3 goes
// straight to the result, a rejected request ends early, and a finished item
// waits while the output register stays full. After reset the tree is
// initialized by a pass over all 2*POOL_UNITS-1 nodes, during which no
// transfer is accepted. One item is in work at a time; a finished result
// waits in the output register while the next is accepted.
module buddy_block_allocator #(
    parameter int POOL_UNITS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // request_units[15:0], block_offset[26:16], zero pad
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status[1:0], granted_offset[11:2],
                                  // block_units[22:12], unavailable_units[33:23], zero pad
);

    localparam int PL    = $clog2(POOL_UNITS);
    localparam int IW    = PL + 1;
    localparam int NODES = 2 * POOL_UNITS - 1;
    localparam int EW    = bba_pkg::EXP_W;
    localparam int WW    = bba_pkg::WIDE_W;

    function automatic logic [WW-1:0] units_of(input logic [EW-1:0] code);
        return (code == bba_pkg::TAKEN) ? '0 : (WW'(1) << code);
    endfunction

    function automatic logic [EW-1:0] exp_max(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [EW-1:0] r;
        priority if (a == bba_pkg::TAKEN) r = b;
        else if (b == bba_pkg::TAKEN)     r = a;
        else if (a > b)                   r = a;
        else                              r = b;
        return r;
    endfunction

    function automatic logic [EW-1:0] ceil_log2(input logic [15:0] r);
        logic [15:0]   rm1;
        logic [EW-1:0] k;
        rm1 = r - 16'd1;
        k   = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (rm1[i])
            begin
                k = EW'(i + 1);
            end
        end
        return k;
    endfunction

    // tree memory
    logic [EW-1:0] mem [NODES];
    logic          mem_we, mem_re;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // control state
    logic          init_reg, init_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [EW-1:0] clr_exp_reg, clr_exp_next;
    logic [EW-1:0] root_reg, root_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // payload state
    logic [15:0]   req_reg, req_next;
    logic [10:0]   off_reg, off_next;
    logic [EW-1:0] k_reg, k_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [EW-1:0] lvl_reg, lvl_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [1:0]    status_reg, status_next;
    logic [9:0]    granted_reg, granted_next;
    logic [10:0]   units_reg, units_next;
    logic [39:0]   m_tdata_reg, m_tdata_next;

    bba_pkg::uword_t            uword;
    bba_pkg::flags_t            flags;
    logic                       busy, accept, out_free;
    logic [bba_pkg::STEP_W-1:0] entry;

    assign s_tready = !busy && !init_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        unique case (s_tuser)
            bba_pkg::MODE_ALLOC: entry = bba_pkg::S_A0;
            bba_pkg::MODE_FREE:  entry = bba_pkg::S_F0;
            bba_pkg::MODE_QUERY: entry = bba_pkg::S_Q0;
            default:             entry = bba_pkg::S_DONE;
        endcase
    end

    always_comb
    begin
        flags.alloc_fail = (req_reg == 16'd0) || ({1'b0, req_reg} > units_of(root_reg));
        flags.lvl_eq_k   = (lvl_reg == k_reg);
        flags.idx_zero   = (idx_reg == '0);
        flags.taken      = (rdata_reg == bba_pkg::TAKEN);
        flags.off_bad    = ({6'd0, off_reg} >= WW'(POOL_UNITS));
        flags.root_full  = (root_reg == EW'(PL));
    end

    bba_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .entry    (entry),
        .flags    (flags),
        .out_free (out_free),
        .busy     (busy),
        .uword    (uword)
    );

    logic [IW-1:0] left_idx, parent_idx, sib_idx;
    logic [IW:0]   grant_wide, clr_p1, clr_p2;
    logic [EW-1:0] up_left, up_right, up_val, plvl;

    always_comb
    begin
        left_idx   = {idx_reg[IW-2:0], 1'b1};
        parent_idx = (idx_reg - IW'(1)) >> 1;
        sib_idx    = idx_reg[0] ? (idx_reg + IW'(1)) : (idx_reg - IW'(1));
        grant_wide = (({1'b0, idx_reg} + (IW+1)'(1)) << k_reg) - (IW+1)'(POOL_UNITS);
        plvl       = lvl_reg + EW'(1);
        up_left    = idx_reg[0] ? cur_reg : rdata_reg;
        up_right   = idx_reg[0] ? rdata_reg : cur_reg;
        up_val     = (cur_reg == lvl_reg && rdata_reg == lvl_reg) ? plvl
                                                                  : exp_max(up_left, up_right);
        clr_p1     = {1'b0, clr_idx_reg} + (IW+1)'(1);
        clr_p2     = {1'b0, clr_idx_reg} + (IW+1)'(2);
    end

    always_comb
    begin
        init_next     = init_reg;
        clr_idx_next  = clr_idx_reg;
        clr_exp_next  = clr_exp_reg;
        root_next     = root_reg;
        m_tvalid_next = m_tvalid_reg;
        req_next      = req_reg;
        off_next      = off_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        lvl_next      = lvl_reg;
        cur_next      = cur_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        units_next    = units_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        waddr         = clr_idx_reg;
        wdata         = clr_exp_reg;
        raddr         = idx_reg;

        // init pass: node gets its level exponent, drop one after the last node of a level
        if (init_reg)
        begin
            mem_we       = 1'b1;
            clr_idx_next = clr_idx_reg + IW'(1);
            if ((clr_p1 & clr_p2) == '0)
            begin
                clr_exp_next = clr_exp_reg - EW'(1);
            end
            if (clr_idx_reg == IW'(NODES - 1))
            begin
                init_next = 1'b0;
            end
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (accept)
        begin
            req_next     = s_tdata[15:0];
            off_next     = s_tdata[26:16];
            k_next       = ceil_log2(s_tdata[15:0]);
            status_next  = bba_pkg::ST_OK;
            granted_next = '0;
            units_next   = '0;
        end

        unique case (uword.uop)
            bba_pkg::U_NONE: ;
            bba_pkg::U_DESC_INIT:
            begin
                idx_next = '0;
                lvl_next = EW'(PL);
            end
            bba_pkg::U_READ_LEFT:
            begin
                mem_re = 1'b1;
                raddr  = left_idx;
            end
            bba_pkg::U_DESC_STEP:
            begin
                if (rdata_reg != bba_pkg::TAKEN && rdata_reg >= k_reg)
                begin
                    idx_next = left_idx;
                end
                else
                begin
                    idx_next = left_idx + IW'(1);
                end
                lvl_next = lvl_reg - EW'(1);
            end
            bba_pkg::U_MARK:
            begin
                mem_we       = 1'b1;
                waddr        = idx_reg;
                wdata        = bba_pkg::TAKEN;
                cur_next     = bba_pkg::TAKEN;
                granted_next = 10'(grant_wide);
                if (idx_reg == '0)
                begin
                    root_next = bba_pkg::TAKEN;
                end
            end
            bba_pkg::U_READ_SIB:
            begin
                mem_re = (idx_reg != '0);
                raddr  = sib_idx;
            end
            bba_pkg::U_UP_WRITE:
            begin
                mem_we   = 1'b1;
                waddr    = parent_idx;
                wdata    = up_val;
                cur_next = up_val;
                idx_next = parent_idx;
                lvl_next = plvl;
                if (parent_idx == '0)
                begin
                    root_next = up_val;
                end
            end
            bba_pkg::U_LEAF_INIT:
            begin
                idx_next = IW'(off_reg) + IW'(POOL_UNITS - 1);
                lvl_next = '0;
            end
            bba_pkg::U_READ_IDX:
            begin
                mem_re = 1'b1;
                raddr  = idx_reg;
            end
            bba_pkg::U_CLIMB:
            begin
                idx_next = parent_idx;
                lvl_next = plvl;
            end
            bba_pkg::U_RESTORE:
            begin
                mem_we   = 1'b1;
                waddr    = idx_reg;
                wdata    = lvl_reg;
                cur_next = lvl_reg;
                if (idx_reg == '0)
                begin
                    root_next = lvl_reg;
                end
            end
            bba_pkg::U_SET_UNITS: units_next  = 11'(WW'(1) << lvl_reg);
            bba_pkg::U_ST1:       status_next = bba_pkg::ST_NO_FIT;
            bba_pkg::U_ST2:       status_next = bba_pkg::ST_RANGE;
            bba_pkg::U_ST3:       status_next = bba_pkg::ST_NOT_ALC;
            bba_pkg::U_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0,
                                     11'(WW'(POOL_UNITS) - units_of(root_reg)),
                                     units_reg, granted_reg, status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= 1'b1;
            clr_idx_reg  <= '0;
            clr_exp_reg  <= EW'(PL);
            root_reg     <= EW'(PL);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            init_reg     <= init_next;
            clr_idx_reg  <= clr_idx_next;
            clr_exp_reg  <= clr_exp_next;
            root_reg     <= root_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        off_reg     <= off_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        lvl_reg     <= lvl_next;
        cur_reg     <= cur_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        units_reg   <= units_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
